FILE: sv/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants of the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int TIMER_COUNT_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int MAX_EVENTS      = 16;
    localparam int EV_CNT_W        = $clog2(MAX_EVENTS + 1);
    localparam int S_DATA_W        = 40;
    localparam int M_DATA_W        = 80;

    typedef enum logic [3:0] {
        OP_TICK       = 4'd0,
        OP_TICK_BY    = 4'd1,
        OP_SERVICE    = 4'd2,
        OP_CREATE     = 4'd3,
        OP_START      = 4'd4,
        OP_STOP       = 4'd5,
        OP_PAUSE      = 4'd6,
        OP_RESUME     = 4'd7,
        OP_RESTART    = 4'd8,
        OP_FREE       = 4'd9,
        OP_SET_PERIOD = 4'd10,
        OP_QUERY      = 4'd11
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD      = 2'd1,
        STAT_NO_FREE  = 2'd2,
        STAT_NONE_DUE = 2'd3
    } status_t;

    localparam logic [1:0] MODE_REPEAT        = 2'd0;
    localparam logic [1:0] MODE_ONE_SHOT      = 2'd1;
    localparam logic [1:0] MODE_ONE_SHOT_FREE = 2'd2;
    localparam logic [1:0] MODE_INVALID       = 2'd3;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_TIME_ADD,
        DP_TICK_MARK,
        DP_SVC_INIT,
        DP_SVC_SCAN,
        DP_SVC_ACT,
        DP_CMD_PREP,
        DP_CMD_EXEC
    } dp_op_t;

    typedef enum logic [2:0] {
        OUT_TICK,
        OUT_NONE_DUE,
        OUT_PEND_MID,
        OUT_PEND_LAST,
        OUT_CMD
    } out_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK_SCAN,
        ST_SVC_SCAN,
        ST_SVC_DECIDE,
        ST_CMD_EXEC,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t   op;
        logic     load_out;
        out_sel_t sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic [3:0] opcode;
        logic       scan_last;
        logic       best_found;
        logic       pend_valid;
        logic       ev_full;
        logic       out_busy;
    } dp_stat_t;

endpackage

FILE: sv/software_timer_bank.sv
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of timers on a shared wrapping time base, driven by command words.
// ----------------------------------------------------------------------------
// Input channel s_*: one command word each, opcode on s_tuser. Output channel
// m_*: result words; m_tlast marks the last result of a command, m_tuser
// flags an expiry event. cfg_we/cfg_wdata load the plain-tick step.
// Slot commands go through the decode, execute and emit states to the output
// register. Tick adds to the time base, then marks due timers one slot per
// cycle. Service takes one full slot scan per event, using the single shared
// compare unit. One command is in work at a time; the next is taken once its
// last result sits in the output register.
// Reset clears time, all slot flags and the output valid; step resets to 1.
// A stalled receiver holds the result word; work that needs the output
// register waits until it frees.
// ----------------------------------------------------------------------------
module software_timer_bank #(
    parameter int TIMER_COUNT = stb_pkg::TIMER_COUNT_DEF,
    parameter int TIME_WIDTH  = stb_pkg::TIME_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // timer_id, timer_mode, start_now, value
    input  logic [stb_pkg::S_DATA_W-1:0]  s_tdata,
    // opcode
    input  logic [3:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, slot_index, remaining_time, elapsed_time, running, paused, ready
    output logic [stb_pkg::M_DATA_W-1:0]  m_tdata,
    // is_expiry
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_wdata
);

    stb_pkg::ctl_cmd_t cmd;
    stb_pkg::dp_stat_t stat;

    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stb_dp #(
        .TIMER_COUNT (TIMER_COUNT),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule

FILE: sv/stb_ctrl.sv
// ----------------------------------------------------------------------------
// stb_ctrl
// Sequencer: decodes each command word and steps the datapath through it.
// ----------------------------------------------------------------------------
module stb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  stb_pkg::dp_stat_t stat,
    output stb_pkg::ctl_cmd_t cmd
);

    stb_pkg::ctl_state_t state_reg, state_next;
    stb_pkg::out_sel_t   out_sel_reg, out_sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= stb_pkg::ST_IDLE;
            out_sel_reg <= stb_pkg::OUT_TICK;
        end
        else
        begin
            state_reg   <= state_next;
            out_sel_reg <= out_sel_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        out_sel_next = out_sel_reg;
        cmd.op       = stb_pkg::DP_NOP;
        cmd.load_out = 1'b0;
        cmd.sel      = out_sel_reg;
        s_tready     = 1'b0;
        case (state_reg)
            stb_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = stb_pkg::DP_LATCH;
                    state_next = stb_pkg::ST_DECODE;
                end
            end
            stb_pkg::ST_DECODE:
            begin
                if (stat.opcode inside {stb_pkg::OP_TICK, stb_pkg::OP_TICK_BY})
                begin
                    cmd.op     = stb_pkg::DP_TIME_ADD;
                    state_next = stb_pkg::ST_TICK_SCAN;
                end
                else if (stat.opcode == stb_pkg::OP_SERVICE)
                begin
                    cmd.op     = stb_pkg::DP_SVC_INIT;
                    state_next = stb_pkg::ST_SVC_SCAN;
                end
                else
                begin
                    cmd.op     = stb_pkg::DP_CMD_PREP;
                    state_next = stb_pkg::ST_CMD_EXEC;
                end
            end
            stb_pkg::ST_TICK_SCAN:
            begin
                cmd.op = stb_pkg::DP_TICK_MARK;
                if (stat.scan_last)
                begin
                    out_sel_next = stb_pkg::OUT_TICK;
                    state_next   = stb_pkg::ST_EMIT;
                end
            end
            stb_pkg::ST_SVC_SCAN:
            begin
                cmd.op = stb_pkg::DP_SVC_SCAN;
                if (stat.scan_last)
                    state_next = stb_pkg::ST_SVC_DECIDE;
            end
            stb_pkg::ST_SVC_DECIDE:
            begin
                if (stat.best_found)
                begin
                    if (!(stat.pend_valid && stat.out_busy))
                    begin
                        cmd.op       = stb_pkg::DP_SVC_ACT;
                        cmd.load_out = stat.pend_valid;
                        cmd.sel      = stb_pkg::OUT_PEND_MID;
                        if (stat.ev_full)
                        begin
                            out_sel_next = stb_pkg::OUT_PEND_LAST;
                            state_next   = stb_pkg::ST_EMIT;
                        end
                        else
                            state_next = stb_pkg::ST_SVC_SCAN;
                    end
                end
                else
                begin
                    out_sel_next = stat.pend_valid ? stb_pkg::OUT_PEND_LAST
                                                   : stb_pkg::OUT_NONE_DUE;
                    state_next   = stb_pkg::ST_EMIT;
                end
            end
            stb_pkg::ST_CMD_EXEC:
            begin
                cmd.op       = stb_pkg::DP_CMD_EXEC;
                out_sel_next = stb_pkg::OUT_CMD;
                state_next   = stb_pkg::ST_EMIT;
            end
            stb_pkg::ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = stb_pkg::ST_IDLE;
                end
            end
            default:
                state_next = stb_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: sv/stb_dp.sv
// ----------------------------------------------------------------------------
// stb_dp
// Datapath: time base, slot state, scan and selection logic, output register.
// ----------------------------------------------------------------------------
module stb_dp #(
    parameter int TIMER_COUNT = stb_pkg::TIMER_COUNT_DEF,
    parameter int TIME_WIDTH  = stb_pkg::TIME_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stb_pkg::ctl_cmd_t             cmd,
    output stb_pkg::dp_stat_t             stat,
    input  logic [stb_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [3:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stb_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_wdata
);

    localparam int N  = TIMER_COUNT;
    localparam int TW = TIME_WIDTH;
    localparam int IW = (N > 1) ? $clog2(N) : 1;

    function automatic logic [31:0] to32(input logic [TW-1:0] x);
        logic [63:0] w;
        w = 64'(x);
        return w[31:0];
    endfunction

    // time base and config
    logic [TW-1:0] now_reg;
    logic [15:0]   step_reg;

    // per-slot flags
    logic [N-1:0] alloc_reg, run_reg, pause_reg, ready_reg, wrap_reg, done_reg;

    // per-slot payload
    logic [1:0]    mode_mem   [N];
    logic [TW-1:0] period_mem [N];
    logic [TW-1:0] start_mem  [N];
    logic [TW-1:0] exp_mem    [N];

    // latched command word
    logic [3:0]  op_reg, id_reg;
    logic [1:0]  tmode_reg;
    logic        snow_reg;
    logic [31:0] val_reg;

    // scan / selection
    logic [IW-1:0] scan_idx_reg, best_idx_reg;
    logic [TW-1:0] best_key_reg;
    logic          best_found_reg;

    // pending expiry event
    logic [IW-1:0]               pend_slot_reg;
    logic [TW-1:0]               pend_rem_reg, pend_ela_reg;
    logic                        pend_run_reg, pend_pau_reg, pend_valid_reg;
    logic [stb_pkg::EV_CNT_W-1:0] count_reg;

    // command execution
    logic [IW-1:0] slot_reg;
    logic [TW-1:0] span_reg;
    logic          ok_reg, free_found_reg;
    logic [1:0]    rep_status_reg;
    logic [3:0]    rep_slot_reg;
    logic          rep_full_reg;

    // output register
    logic          out_valid_reg;
    logic [1:0]    o_status_reg;
    logic [3:0]    o_slot_reg;
    logic          o_exp_reg, o_run_reg, o_pau_reg, o_rdy_reg, o_last_reg;
    logic [31:0]   o_rem_reg, o_ela_reg;

    // combinational
    logic [IW-1:0] rd_idx, id_idx, free_idx, idx_inc;
    logic [TW-1:0] r_exp, r_start, r_period, arm_span, arm_exp, key;
    logic [1:0]    r_mode;
    logic          r_alloc, r_run, r_pause, r_ready, r_wrap;
    logic          arm_wrap, due, elig, take, free_found, id_ok, wrong, good;
    logic          out_busy, scan_last, svc_keep;

    assign out_busy  = out_valid_reg && !m_tready;
    assign scan_last = (scan_idx_reg == IW'(N - 1));
    assign idx_inc   = scan_last ? '0 : IW'(scan_idx_reg + 1'b1);
    assign id_idx    = IW'(id_reg);
    assign id_ok     = (32'(id_reg) < 32'(N));

    always_comb
    begin
        case (cmd.op)
            stb_pkg::DP_TICK_MARK, stb_pkg::DP_SVC_SCAN: rd_idx = scan_idx_reg;
            stb_pkg::DP_SVC_ACT:                         rd_idx = best_idx_reg;
            stb_pkg::DP_CMD_PREP:                        rd_idx = id_idx;
            default:                                     rd_idx = slot_reg;
        endcase
    end

    assign r_exp    = exp_mem[rd_idx];
    assign r_start  = start_mem[rd_idx];
    assign r_period = period_mem[rd_idx];
    assign r_mode   = mode_mem[rd_idx];
    assign r_alloc  = alloc_reg[rd_idx];
    assign r_run    = run_reg[rd_idx];
    assign r_pause  = pause_reg[rd_idx];
    assign r_ready  = ready_reg[rd_idx];
    assign r_wrap   = wrap_reg[rd_idx];

    assign arm_span = (cmd.op == stb_pkg::DP_SVC_ACT) ? r_period : span_reg;
    assign arm_exp  = TW'(now_reg + arm_span);
    assign arm_wrap = (arm_exp < now_reg);
    assign svc_keep = (r_mode != stb_pkg::MODE_ONE_SHOT_FREE);

    assign due  = !(now_reg < r_exp) && !(r_wrap && (now_reg >= r_start));
    assign elig = r_alloc && r_run && r_ready && !done_reg[rd_idx];
    assign key  = TW'(r_exp - now_reg);
    assign take = elig && ((scan_idx_reg == '0) || !best_found_reg || (key < best_key_reg));

    assign wrong = ((op_reg == stb_pkg::OP_START)  && r_run)
                || ((op_reg == stb_pkg::OP_PAUSE)  && !r_run)
                || ((op_reg == stb_pkg::OP_RESUME) && !r_pause);
    assign good  = ok_reg && !wrong;

    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!alloc_reg[i])
            begin
                free_idx   = IW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign stat.opcode     = op_reg;
    assign stat.scan_last  = scan_last;
    assign stat.best_found = best_found_reg;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.ev_full    = (count_reg == stb_pkg::EV_CNT_W'(stb_pkg::MAX_EVENTS - 1));
    assign stat.out_busy   = out_busy;

    // slot payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.op == stb_pkg::DP_CMD_EXEC && good)
        begin
            case (op_reg)
                stb_pkg::OP_CREATE:
                begin
                    mode_mem[slot_reg]   <= tmode_reg;
                    period_mem[slot_reg] <= TW'(val_reg);
                    start_mem[slot_reg]  <= now_reg;
                    exp_mem[slot_reg]    <= arm_exp;
                end
                stb_pkg::OP_START, stb_pkg::OP_STOP, stb_pkg::OP_RESUME,
                stb_pkg::OP_RESTART:
                begin
                    start_mem[slot_reg] <= now_reg;
                    exp_mem[slot_reg]   <= arm_exp;
                end
                stb_pkg::OP_PAUSE:
                    start_mem[slot_reg] <= now_reg;
                stb_pkg::OP_SET_PERIOD:
                    period_mem[slot_reg] <= TW'(val_reg);
                default:
                    ;
            endcase
        end
        if (cmd.op == stb_pkg::DP_SVC_ACT && svc_keep)
        begin
            start_mem[best_idx_reg] <= now_reg;
            exp_mem[best_idx_reg]   <= arm_exp;
        end
    end

    // command word and working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            stb_pkg::DP_LATCH:
            begin
                op_reg    <= s_tuser;
                id_reg    <= s_tdata[3:0];
                tmode_reg <= s_tdata[5:4];
                snow_reg  <= s_tdata[6];
                val_reg   <= s_tdata[38:7];
            end
            stb_pkg::DP_SVC_SCAN:
            begin
                if (take)
                begin
                    best_idx_reg <= scan_idx_reg;
                    best_key_reg <= key;
                end
            end
            stb_pkg::DP_SVC_ACT:
            begin
                pend_slot_reg <= best_idx_reg;
                pend_rem_reg  <= best_key_reg;
                pend_ela_reg  <= TW'(now_reg - r_start);
                pend_run_reg  <= svc_keep && (r_mode == stb_pkg::MODE_REPEAT) && r_run;
                pend_pau_reg  <= svc_keep && r_pause;
            end
            stb_pkg::DP_CMD_PREP:
            begin
                slot_reg       <= (op_reg == stb_pkg::OP_CREATE) ? free_idx : id_idx;
                free_found_reg <= free_found;
                if (op_reg == stb_pkg::OP_CREATE)
                    span_reg <= TW'(val_reg);
                else if ((op_reg == stb_pkg::OP_RESUME)
                         || ((op_reg == stb_pkg::OP_START) && r_pause))
                    span_reg <= TW'(r_exp - r_start);
                else
                    span_reg <= r_period;
            end
            stb_pkg::DP_CMD_EXEC:
            begin
                if (good)
                begin
                    rep_status_reg <= stb_pkg::STAT_OK;
                    rep_slot_reg   <= (op_reg == stb_pkg::OP_CREATE) ? 4'(slot_reg) : id_reg;
                    rep_full_reg   <= (op_reg != stb_pkg::OP_FREE);
                end
                else
                begin
                    rep_full_reg <= 1'b0;
                    if (op_reg == stb_pkg::OP_CREATE)
                    begin
                        rep_slot_reg   <= 4'd0;
                        rep_status_reg <= ((tmode_reg != stb_pkg::MODE_INVALID)
                                           && !free_found_reg) ? stb_pkg::STAT_NO_FREE
                                                               : stb_pkg::STAT_BAD;
                    end
                    else
                    begin
                        rep_slot_reg   <= id_reg;
                        rep_status_reg <= stb_pkg::STAT_BAD;
                    end
                end
            end
            default:
                ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            step_reg       <= 16'd1;
            alloc_reg      <= '0;
            run_reg        <= '0;
            pause_reg      <= '0;
            ready_reg      <= '0;
            wrap_reg       <= '0;
            done_reg       <= '0;
            scan_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            ok_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                step_reg <= cfg_wdata;
            case (cmd.op)
                stb_pkg::DP_TIME_ADD:
                begin
                    now_reg      <= (op_reg == stb_pkg::OP_TICK) ? TW'(now_reg + TW'(step_reg))
                                                                 : TW'(now_reg + TW'(val_reg));
                    scan_idx_reg <= '0;
                end
                stb_pkg::DP_TICK_MARK:
                begin
                    if (r_alloc && r_run && due)
                        ready_reg[rd_idx] <= 1'b1;
                    scan_idx_reg <= idx_inc;
                end
                stb_pkg::DP_SVC_INIT:
                begin
                    done_reg       <= '0;
                    pend_valid_reg <= 1'b0;
                    count_reg      <= '0;
                    scan_idx_reg   <= '0;
                end
                stb_pkg::DP_SVC_SCAN:
                begin
                    best_found_reg <= (scan_idx_reg == '0) ? elig : (best_found_reg || elig);
                    scan_idx_reg   <= idx_inc;
                end
                stb_pkg::DP_SVC_ACT:
                begin
                    done_reg[rd_idx]  <= 1'b1;
                    pend_valid_reg    <= 1'b1;
                    count_reg         <= stb_pkg::EV_CNT_W'(count_reg + 1'b1);
                    scan_idx_reg      <= '0;
                    ready_reg[rd_idx] <= 1'b0;
                    if (svc_keep)
                    begin
                        wrap_reg[rd_idx] <= arm_wrap;
                        if (r_mode != stb_pkg::MODE_REPEAT)
                            run_reg[rd_idx] <= 1'b0;
                    end
                    else
                    begin
                        alloc_reg[rd_idx] <= 1'b0;
                        run_reg[rd_idx]   <= 1'b0;
                        pause_reg[rd_idx] <= 1'b0;
                        wrap_reg[rd_idx]  <= 1'b0;
                    end
                end
                stb_pkg::DP_CMD_PREP:
                begin
                    if (op_reg == stb_pkg::OP_CREATE)
                        ok_reg <= (tmode_reg != stb_pkg::MODE_INVALID) && free_found;
                    else
                        ok_reg <= (op_reg inside {[stb_pkg::OP_START:stb_pkg::OP_QUERY]})
                                  && id_ok && alloc_reg[id_idx];
                end
                stb_pkg::DP_CMD_EXEC:
                begin
                    if (good)
                    begin
                        case (op_reg)
                            stb_pkg::OP_CREATE:
                            begin
                                alloc_reg[rd_idx] <= 1'b1;
                                run_reg[rd_idx]   <= snow_reg;
                                pause_reg[rd_idx] <= 1'b0;
                                ready_reg[rd_idx] <= 1'b0;
                                wrap_reg[rd_idx]  <= arm_wrap;
                            end
                            stb_pkg::OP_START:
                            begin
                                if (!r_pause)
                                    ready_reg[rd_idx] <= 1'b0;
                                pause_reg[rd_idx] <= 1'b0;
                                run_reg[rd_idx]   <= 1'b1;
                                wrap_reg[rd_idx]  <= arm_wrap;
                            end
                            stb_pkg::OP_STOP:
                            begin
                                run_reg[rd_idx]   <= 1'b0;
                                pause_reg[rd_idx] <= 1'b0;
                                ready_reg[rd_idx] <= 1'b0;
                                wrap_reg[rd_idx]  <= arm_wrap;
                            end
                            stb_pkg::OP_PAUSE:
                            begin
                                run_reg[rd_idx]   <= 1'b0;
                                pause_reg[rd_idx] <= 1'b1;
                            end
                            stb_pkg::OP_RESUME:
                            begin
                                pause_reg[rd_idx] <= 1'b0;
                                run_reg[rd_idx]   <= 1'b1;
                                wrap_reg[rd_idx]  <= arm_wrap;
                            end
                            stb_pkg::OP_RESTART:
                            begin
                                pause_reg[rd_idx] <= 1'b0;
                                ready_reg[rd_idx] <= 1'b0;
                                wrap_reg[rd_idx]  <= arm_wrap;
                            end
                            stb_pkg::OP_FREE:
                            begin
                                alloc_reg[rd_idx] <= 1'b0;
                                run_reg[rd_idx]   <= 1'b0;
                                pause_reg[rd_idx] <= 1'b0;
                                ready_reg[rd_idx] <= 1'b0;
                                wrap_reg[rd_idx]  <= 1'b0;
                            end
                            default:
                                ;
                        endcase
                    end
                end
                default:
                    ;
            endcase
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_status_reg <= stb_pkg::STAT_OK;
            o_slot_reg   <= 4'd0;
            o_exp_reg    <= 1'b0;
            o_rem_reg    <= 32'd0;
            o_ela_reg    <= 32'd0;
            o_run_reg    <= 1'b0;
            o_pau_reg    <= 1'b0;
            o_rdy_reg    <= 1'b0;
            o_last_reg   <= 1'b1;
            case (cmd.sel)
                stb_pkg::OUT_NONE_DUE:
                    o_status_reg <= stb_pkg::STAT_NONE_DUE;
                stb_pkg::OUT_PEND_MID, stb_pkg::OUT_PEND_LAST:
                begin
                    o_slot_reg <= 4'(pend_slot_reg);
                    o_exp_reg  <= 1'b1;
                    o_rem_reg  <= to32(pend_rem_reg);
                    o_ela_reg  <= to32(pend_ela_reg);
                    o_run_reg  <= pend_run_reg;
                    o_pau_reg  <= pend_pau_reg;
                    o_last_reg <= (cmd.sel == stb_pkg::OUT_PEND_LAST);
                end
                stb_pkg::OUT_CMD:
                begin
                    o_status_reg <= rep_status_reg;
                    o_slot_reg   <= rep_slot_reg;
                    if (rep_full_reg)
                    begin
                        o_rem_reg <= to32(TW'(r_exp - now_reg));
                        o_ela_reg <= to32(TW'(now_reg - r_start));
                        o_run_reg <= r_run;
                        o_pau_reg <= r_pause;
                        o_rdy_reg <= r_ready;
                    end
                end
                default:
                    ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, o_rdy_reg, o_pau_reg, o_run_reg, o_ela_reg, o_rem_reg,
                       o_slot_reg, o_status_reg};
    assign m_tuser  = o_exp_reg;
    assign m_tlast  = o_last_reg;

endmodule

FILE: sv/stb_checker.sv
// ----------------------------------------------------------------------------
// stb_checker
// Port-level checks for the software timer bank.
// ----------------------------------------------------------------------------
module stb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [stb_pkg::S_DATA_W-1:0]  s_tdata,
    input logic [3:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [stb_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [0:0]                    m_tuser,
    input logic                          m_tlast,
    input logic                          cfg_we,
    input logic [15:0]                   cfg_wdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    a_event_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[1:0] == stb_pkg::STAT_OK)
        else $error("expiry event with bad status");

    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("command reply not last");

endmodule

bind software_timer_bank stb_checker u_stb_checker (.*);

FILE: dv/software_timer_bank_test.sv
// ----------------------------------------------------------------------------
// software_timer_bank_test
// Self-checking bench for the software timer bank. A short table of directed
// commands is followed by weighted random command words under several tick
// steps. Every command is run through an in-bench model of the timer bank,
// and each result word is checked field by field in arrival order. Both sides
// idle at random, with one calm stretch and drain pauses between phases.
// ----------------------------------------------------------------------------
module software_timer_bank_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 16;
    localparam int STALL_CAP = 5000;

    typedef struct {
        logic [1:0]  st;
        logic [3:0]  slot;
        logic        ex;
        logic [31:0] rem;
        logic [31:0] ela;
        logic        run;
        logic        pau;
        logic        rdy;
        logic        lst;
    } result_t;

    typedef struct {
        logic [3:0]  op;
        logic [3:0]  id;
        logic [1:0]  mode;
        logic        go;
        logic [31:0] val;
        bit          typed;
        logic [1:0]  tstat;
    } cmd_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [stb_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic [3:0]                   s_tuser = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [stb_pkg::M_DATA_W-1:0] m_tdata;
    logic [0:0]                   m_tuser;
    logic                         m_tlast;
    logic                         cfg_we = 1'b0;
    logic [15:0]                  cfg_wdata = '0;

    // timer bank model state
    logic [31:0] now_t;
    logic [15:0] tick_step;
    bit          alloc_q [SLOTS];
    bit          run_q   [SLOTS];
    bit          pause_q [SLOTS];
    bit          ready_q [SLOTS];
    bit          wrap_q  [SLOTS];
    logic [1:0]  mode_q  [SLOTS];
    logic [31:0] period_q[SLOTS];
    logic [31:0] stamp_q [SLOTS];
    logic [31:0] expiry_q[SLOTS];

    result_t  awaited[$];
    cmd_row_t rows[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       calm = 1'b0;

    software_timer_bank u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic push_res(input logic [1:0] st, input int slot, input bit ex,
                            input logic [31:0] rem, input logic [31:0] ela,
                            input bit run, input bit pau, input bit rdy, input bit lst);
        result_t r;
        r.st = st; r.slot = slot[3:0]; r.ex = ex; r.rem = rem; r.ela = ela;
        r.run = run; r.pau = pau; r.rdy = rdy; r.lst = lst;
        awaited.push_back(r);
    endtask

    task automatic arm_slot(input int i, input logic [31:0] span);
        stamp_q[i]  = now_t;
        expiry_q[i] = now_t + span;
        wrap_q[i]   = expiry_q[i] < stamp_q[i];
    endtask

    function automatic bit slot_due(input int i);
        if (now_t < expiry_q[i])
            return 1'b0;
        if (wrap_q[i] && now_t >= stamp_q[i])
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic release_slot(input int i);
        alloc_q[i] = 0; run_q[i] = 0; pause_q[i] = 0; ready_q[i] = 0; wrap_q[i] = 0;
    endtask

    task automatic advance_time(input logic [31:0] amount);
        now_t = now_t + amount;
        for (int i = 0; i < SLOTS; i++)
            if (alloc_q[i] && run_q[i] && slot_due(i))
                ready_q[i] = 1;
        push_res(stb_pkg::STAT_OK, 0, 0, 0, 0, 0, 0, 0, 1);
    endtask

    task automatic service_due();
        bit          done[SLOTS];
        int          n;
        int          best;
        logic [31:0] bkey;
        logic [31:0] key;
        logic [31:0] ela;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            done[i] = 0;
        while (n < stb_pkg::MAX_EVENTS) begin
            best = -1;
            bkey = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (done[i] || !alloc_q[i] || !run_q[i] || !ready_q[i])
                    continue;
                key = expiry_q[i] - now_t;
                if (best < 0 || key < bkey)
                begin
                    best = i;
                    bkey = key;
                end
            end
            if (best < 0)
                break;
            done[best] = 1;
            ela = now_t - stamp_q[best];
            if (mode_q[best] == stb_pkg::MODE_ONE_SHOT_FREE)
                release_slot(best);
            else
            begin
                ready_q[best] = 0;
                arm_slot(best, period_q[best]);
                if (mode_q[best] != stb_pkg::MODE_REPEAT)
                    run_q[best] = 0;
            end
            push_res(stb_pkg::STAT_OK, best, 1, bkey, ela, run_q[best], pause_q[best],
                     ready_q[best], 0);
            n++;
        end
        if (n == 0)
            push_res(stb_pkg::STAT_NONE_DUE, 0, 0, 0, 0, 0, 0, 0, 1);
        else
            awaited[awaited.size()-1].lst = 1;
    endtask

    task automatic slot_reply(input int i);
        push_res(stb_pkg::STAT_OK, i, 0, expiry_q[i] - now_t, now_t - stamp_q[i],
                 run_q[i], pause_q[i], ready_q[i], 1);
    endtask

    task automatic predict_command(input logic [3:0] op, input logic [3:0] id,
                                   input logic [1:0] mode, input logic go,
                                   input logic [31:0] val);
        int i;
        int s;
        i = id;
        if (op == stb_pkg::OP_TICK)
            advance_time({16'd0, tick_step});
        else if (op == stb_pkg::OP_TICK_BY)
            advance_time(val);
        else if (op == stb_pkg::OP_SERVICE)
            service_due();
        else if (op == stb_pkg::OP_CREATE)
        begin
            if (mode == stb_pkg::MODE_INVALID)
                push_res(stb_pkg::STAT_BAD, 0, 0, 0, 0, 0, 0, 0, 1);
            else
            begin
                for (s = 0; s < SLOTS; s++)
                    if (!alloc_q[s])
                        break;
                if (s >= SLOTS)
                    push_res(stb_pkg::STAT_NO_FREE, 0, 0, 0, 0, 0, 0, 0, 1);
                else
                begin
                    release_slot(s);
                    alloc_q[s]  = 1;
                    mode_q[s]   = mode;
                    period_q[s] = val;
                    arm_slot(s, val);
                    run_q[s] = go;
                    slot_reply(s);
                end
            end
        end
        else if (op > stb_pkg::OP_QUERY || !alloc_q[i])
            push_res(stb_pkg::STAT_BAD, i, 0, 0, 0, 0, 0, 0, 1);
        else
        begin
            case (op)
                stb_pkg::OP_START:
                    if (run_q[i])
                        push_res(stb_pkg::STAT_BAD, i, 0, 0, 0, 0, 0, 0, 1);
                    else
                    begin
                        if (pause_q[i])
                        begin
                            arm_slot(i, expiry_q[i] - stamp_q[i]);
                            pause_q[i] = 0;
                        end
                        else
                        begin
                            ready_q[i] = 0;
                            arm_slot(i, period_q[i]);
                        end
                        run_q[i] = 1;
                        slot_reply(i);
                    end
                stb_pkg::OP_STOP:
                begin
                    run_q[i] = 0; pause_q[i] = 0; ready_q[i] = 0;
                    arm_slot(i, period_q[i]);
                    slot_reply(i);
                end
                stb_pkg::OP_PAUSE:
                    if (!run_q[i])
                        push_res(stb_pkg::STAT_BAD, i, 0, 0, 0, 0, 0, 0, 1);
                    else
                    begin
                        run_q[i] = 0; pause_q[i] = 1; stamp_q[i] = now_t;
                        slot_reply(i);
                    end
                stb_pkg::OP_RESUME:
                    if (!pause_q[i])
                        push_res(stb_pkg::STAT_BAD, i, 0, 0, 0, 0, 0, 0, 1);
                    else
                    begin
                        arm_slot(i, expiry_q[i] - stamp_q[i]);
                        pause_q[i] = 0; run_q[i] = 1;
                        slot_reply(i);
                    end
                stb_pkg::OP_RESTART:
                begin
                    pause_q[i] = 0; ready_q[i] = 0;
                    arm_slot(i, period_q[i]);
                    slot_reply(i);
                end
                stb_pkg::OP_FREE:
                begin
                    release_slot(i);
                    push_res(stb_pkg::STAT_OK, i, 0, 0, 0, 0, 0, 0, 1);
                end
                stb_pkg::OP_SET_PERIOD:
                begin
                    period_q[i] = val;
                    slot_reply(i);
                end
                default:
                    slot_reply(i);
            endcase
        end
    endtask

    task automatic send_word(input cmd_row_t c);
        int first_new;
        while (!calm && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        first_new = awaited.size();
        predict_command(c.op, c.id, c.mode, c.go, c.val);
        if (c.typed)
            awaited[first_new] = '{c.tstat, (c.tstat == stb_pkg::STAT_BAD) ? c.id : 4'd0,
                                   0, 0, 0, 0, 0, 0, 1};
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {1'b0, c.val, c.go, c.mode, c.id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_step(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tick_step = v;
        @(posedge clk);
    endtask

    task automatic add_row(input logic [3:0] op, input logic [3:0] id, input logic [1:0] mode,
                           input logic go, input logic [31:0] val,
                           input bit typed, input logic [1:0] tstat);
        cmd_row_t c;
        c = '{op, id, mode, go, val, typed, tstat};
        rows.push_back(c);
    endtask

    function automatic cmd_row_t random_cmd();
        cmd_row_t c;
        int       w;
        w = $urandom_range(99);
        c.typed = 0;
        c.tstat = stb_pkg::STAT_OK;
        c.id    = $urandom_range(99) < 80 ? 4'($urandom_range(5)) : 4'($urandom_range(15));
        c.mode  = 2'($urandom_range(3));
        c.go    = $urandom_range(3) != 0;
        if (w < 14)       c.op = stb_pkg::OP_TICK;
        else if (w < 30)  c.op = stb_pkg::OP_TICK_BY;
        else if (w < 45)  c.op = stb_pkg::OP_SERVICE;
        else if (w < 62)  c.op = stb_pkg::OP_CREATE;
        else if (w < 98)  c.op = 4'($urandom_range(stb_pkg::OP_QUERY, stb_pkg::OP_START));
        else              c.op = 4'($urandom_range(15, 12));
        w = $urandom_range(99);
        if (c.op == stb_pkg::OP_TICK_BY)
            c.val = w < 70 ? 32'($urandom_range(20)) : w < 90 ? 32'($urandom())
                                                             : 32'(-$urandom_range(30));
        else
            c.val = w < 75 ? 32'($urandom_range(40)) : 32'($urandom());
        return c;
    endfunction

    // result checker and idling of the receiver
    always @(posedge clk)
    begin
        result_t w;
        if (m_tvalid && m_tready)
        begin
            if (awaited.size() == 0)
                report("unexpected word", m_tdata[31:0], 0);
            else
            begin
                w = awaited.pop_front();
                if (m_tdata[1:0] != w.st)    report("status", m_tdata[1:0], w.st);
                if (m_tdata[5:2] != w.slot)  report("slot_index", m_tdata[5:2], w.slot);
                if (m_tuser[0] != w.ex)      report("is_expiry", m_tuser[0], w.ex);
                if (m_tdata[37:6] != w.rem)  report("remaining", m_tdata[37:6], w.rem);
                if (m_tdata[69:38] != w.ela) report("elapsed", m_tdata[69:38], w.ela);
                if (m_tdata[70] != w.run)    report("running", m_tdata[70], w.run);
                if (m_tdata[71] != w.pau)    report("paused", m_tdata[71], w.pau);
                if (m_tdata[72] != w.rdy)    report("ready", m_tdata[72], w.rdy);
                if (m_tlast != w.lst)        report("last", m_tlast, w.lst);
            end
        end
        if (rst_n)
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (s_tvalid || awaited.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        cmd_row_t c;
        now_t = 0;
        tick_step = 16'd1;
        for (int i = 0; i < SLOTS; i++)
        begin
            release_slot(i);
            mode_q[i] = 0; period_q[i] = 0; stamp_q[i] = 0; expiry_q[i] = 0;
        end
        add_row(stb_pkg::OP_TICK, 0, 0, 0, 0, 1, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_SERVICE, 0, 0, 0, 0, 1, stb_pkg::STAT_NONE_DUE);
        add_row(stb_pkg::OP_QUERY, 0, 0, 0, 0, 1, stb_pkg::STAT_BAD);
        add_row(4'd12, 5, 0, 0, 0, 1, stb_pkg::STAT_BAD);
        add_row(4'd15, 15, 3, 1, 32'hFFFF_FFFF, 1, stb_pkg::STAT_BAD);
        add_row(stb_pkg::OP_CREATE, 0, stb_pkg::MODE_INVALID, 1, 7, 1, stb_pkg::STAT_BAD);
        add_row(stb_pkg::OP_CREATE, 0, stb_pkg::MODE_REPEAT, 1, 3, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_CREATE, 0, stb_pkg::MODE_ONE_SHOT, 1, 0, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_CREATE, 0, stb_pkg::MODE_ONE_SHOT_FREE, 1, 2, 0,
                stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_CREATE, 0, stb_pkg::MODE_REPEAT, 0, 32'hFFFF_FFFF, 0,
                stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_START, 1, 0, 0, 0, 1, stb_pkg::STAT_BAD);
        add_row(stb_pkg::OP_PAUSE, 3, 0, 0, 0, 1, stb_pkg::STAT_BAD);
        add_row(stb_pkg::OP_RESUME, 0, 0, 0, 0, 1, stb_pkg::STAT_BAD);
        add_row(stb_pkg::OP_TICK_BY, 0, 0, 0, 5, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_SERVICE, 0, 0, 0, 0, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_PAUSE, 0, 0, 0, 0, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_TICK_BY, 0, 0, 0, 32'hFFFF_FFF0, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_RESUME, 0, 0, 0, 0, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_START, 3, 0, 0, 0, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_RESTART, 3, 0, 0, 0, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_SET_PERIOD, 3, 0, 0, 7, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_STOP, 0, 0, 0, 0, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_FREE, 1, 0, 0, 0, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_QUERY, 0, 0, 0, 0, 0, stb_pkg::STAT_OK);
        add_row(stb_pkg::OP_SERVICE, 0, 0, 0, 0, 0, stb_pkg::STAT_OK);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        write_step(16'd1);

        foreach (rows[k])
            send_word(rows[k]);
        drain();

        write_step(16'hFFFF);
        calm = 1'b1;
        repeat (30) send_word(random_cmd());
        calm = 1'b0;
        drain();

        write_step(16'd1);
        repeat (40) send_word(random_cmd());
        drain();

        write_step(16'($urandom_range(65535, 1)));
        repeat (45) send_word(random_cmd());
        drain();
        repeat (300) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
